[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CHK_PROP(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Condition must never be true outside reset.
`define CHK_NEVER(lbl, clk_sig, rstn_sig, cond, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error(msg);

`else

`define CHK_PROP(lbl, clk_sig, rstn_sig, prop, msg)
`define CHK_NEVER(lbl, clk_sig, rstn_sig, cond, msg)

`endif

`endif

[rtl/iile_pkg.sv]
// ----------------------------------------------------------------------------
// iile_pkg
// Types and constants shared by the list engine controller and datapath.
// ----------------------------------------------------------------------------
package iile_pkg;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        RQ_APPEND  = 3'd0,
        RQ_INSERT  = 3'd1,
        RQ_REMOVE  = 3'd2,
        RQ_GET     = 3'd3,
        RQ_FIND    = 3'd4,
        RQ_COUNT   = 3'd5,
        RQ_REVERSE = 3'd6,
        RQ_CLEAR   = 3'd7
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } st_t;

    typedef enum logic [2:0] {
        IX_HOLD,
        IX_ZERO,
        IX_POS,
        IX_CNT_DEC,
        IX_INC,
        IX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        JX_HOLD,
        JX_CNT_DEC,
        JX_DEC
    } jdx_op_t;

    typedef enum logic [1:0] {
        CN_HOLD,
        CN_INC,
        CN_DEC,
        CN_ZERO
    } cnt_op_t;

    // Shift move: read at idx now, write the word one place up or down next cycle
    typedef enum logic [1:0] {
        MV_NONE,
        MV_UP,
        MV_DN
    } mv_t;

    typedef enum logic [1:0] {
        WA_POS,
        WA_CNT,
        WA_IDX,
        WA_JDX
    } wa_t;

    typedef struct packed {
        logic    load_in;
        logic    init;
        logic    st_set;
        st_t     st_code;
        idx_op_t idx_op;
        jdx_op_t jdx_op;
        cnt_op_t cnt_op;
        logic    rd_jdx;
        mv_t     mv;
        logic    scan_rd;
        logic    wr_en;
        wa_t     wa_sel;
        logic    wd_tmp;
        logic    tmp_load;
        logic    capt;
        logic    out_load;
    } ctl_cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic cnt_gt1;
        logic idx_eq_pos;
        logic idx_lt_cnt;
        logic idx_lt_jdx;
        logic match;
        logic scan_pend;
    } dp_stat_t;

endpackage

[rtl/indexed_integer_list_engine.sv]
// ----------------------------------------------------------------------------
// indexed_integer_list_engine
// Ordered list of signed 32-bit words with append/insert/remove/get/find/
// count/reverse/clear requests, one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request beat on the s_ side; one result beat comes back on the
//   m_ side carrying status, data word and the list length after the request.
//   Requests are handled one at a time; s_tready is high only while the
//   sequencer is idle, and goes high again as soon as the result is parked in
//   the output register, even if the receiver has not taken it yet.
// Steps (L = length, P = position):
//   append, clear, errors, reverse of fewer than two entries: decode, then
//   finish; get: read at P, capture; insert: shift entries P..L-1 up one
//   place, then write at P; remove: read at P, capture, shift the entries
//   above P down; find, count: scan up to L; reverse: swap pairs from both
//   ends. The element walks move one entry per cycle through the single
//   write port of the entry RAM; a swap reads both ends and writes them back
//   through one holding register, one access per cycle.
// Reset: the length clears to zero and no result is pending; the entry RAM is
//   not cleared, as entries are only read below the length.
// Stall: a held result waits in the output register; a following request is
//   still processed and then holds in its final step until the slot frees.
// ----------------------------------------------------------------------------
module indexed_integer_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [38:32] list_length, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    import iile_pkg::*;

    `include "assert_macros.svh"

    ctl_cmd_t                 cmd;
    dp_stat_t                 stat;
    logic [ST_W-1:0]          res_status;
    logic signed [DATA_W-1:0] res_data;
    logic [LEN_W-1:0]         res_len;

    // Sequencer: decodes each request and drives the datapath step by step
    iile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: entry RAM, length, walk indices and the result register
    iile_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (req_t'(s_tuser[2:0])),
        .in_pos     (s_tdata[POS_W-1:0]),
        .in_val     (s_tdata[POS_W+DATA_W-1:POS_W]),
        .out_status (res_status),
        .out_data   (res_data),
        .out_len    (res_len)
    );

    assign m_tdata = {1'b0, res_len, res_data};
    assign m_tuser = res_status;

    // Idle sequencer must never write the entry RAM
    `CHK_NEVER(a_no_write_idle, clk, rst_n, s_tready && cmd.wr_en, "RAM write while idle")
    // A taken request keeps the input closed on the next cycle
    `CHK_PROP(a_one_request, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "second request taken")
    // Length never grows past the store size
    `CHK_NEVER(a_no_overfill, clk, rst_n, stat.full && (cmd.cnt_op == CN_INC), "list overfilled")
    // Parking a result always raises m_tvalid
    `CHK_PROP(a_result_shown, clk, rst_n, cmd.out_load |=> m_tvalid, "result lost")

endmodule

[rtl/iile_ram.sv]
// ----------------------------------------------------------------------------
// iile_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/iile_ctrl.sv]
// ----------------------------------------------------------------------------
// iile_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module iile_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  iile_pkg::dp_stat_t   stat,
    output iile_pkg::ctl_cmd_t   cmd
);

    import iile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_PUT,
        S_RD_POS,
        S_CAPT,
        S_RM_SHIFT,
        S_SCAN,
        S_REV_RI,
        S_REV_RJ,
        S_REV_WJ,
        S_REV_WI,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   vld_reg, vld_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = vld_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load_in = in_valid && (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.init = 1'b1;
                unique case (stat.req) inside
                    RQ_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_CNT;
                            cmd.cnt_op = CN_INC;
                        end
                        state_next = S_FIN;
                    end
                    RQ_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_RANGE;
                            state_next  = S_FIN;
                        end
                        else if (stat.full)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else if (stat.pos_ge_cnt)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.idx_op = IX_CNT_DEC;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    RQ_REMOVE, RQ_GET:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_RANGE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.idx_op = IX_POS;
                            state_next = S_RD_POS;
                        end
                    end
                    RQ_FIND, RQ_COUNT:
                    begin
                        cmd.idx_op = IX_ZERO;
                        state_next = S_SCAN;
                    end
                    RQ_REVERSE:
                    begin
                        if (stat.cnt_gt1)
                        begin
                            cmd.idx_op = IX_ZERO;
                            cmd.jdx_op = JX_CNT_DEC;
                            state_next = S_REV_RI;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    RQ_CLEAR:
                    begin
                        cmd.cnt_op = CN_ZERO;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                cmd.mv = MV_UP;
                if (stat.idx_eq_pos)
                begin
                    state_next = S_INS_DRAIN;
                end
                else
                begin
                    cmd.idx_op = IX_DEC;
                end
            end
            S_INS_DRAIN:
            begin
                state_next = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_POS;
                cmd.cnt_op = CN_INC;
                state_next = S_FIN;
            end
            S_RD_POS:
            begin
                cmd.idx_op = IX_INC;
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                cmd.capt   = 1'b1;
                state_next = (stat.req == RQ_REMOVE) ? S_RM_SHIFT : S_FIN;
            end
            S_RM_SHIFT:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.mv     = MV_DN;
                    cmd.idx_op = IX_INC;
                end
                else
                begin
                    cmd.cnt_op = CN_DEC;
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (stat.match && (stat.req == RQ_FIND))
                begin
                    state_next = S_FIN;
                end
                else if (stat.idx_lt_cnt)
                begin
                    cmd.scan_rd = 1'b1;
                    cmd.idx_op  = IX_INC;
                end
                else if (!stat.scan_pend)
                begin
                    state_next = S_FIN;
                end
            end
            S_REV_RI:
            begin
                state_next = stat.idx_lt_jdx ? S_REV_RJ : S_FIN;
            end
            S_REV_RJ:
            begin
                cmd.rd_jdx   = 1'b1;
                cmd.tmp_load = 1'b1;
                state_next   = S_REV_WJ;
            end
            S_REV_WJ:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wa_sel   = WA_JDX;
                cmd.wd_tmp   = 1'b1;
                cmd.tmp_load = 1'b1;
                state_next   = S_REV_WI;
            end
            S_REV_WI:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_IDX;
                cmd.wd_tmp = 1'b1;
                cmd.idx_op = IX_INC;
                cmd.jdx_op = JX_DEC;
                state_next = S_REV_RI;
            end
            S_FIN:
            begin
                if (!vld_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

endmodule

[rtl/iile_dpath.sv]
// ----------------------------------------------------------------------------
// iile_dpath
// List datapath: entry RAM, length, walk indices, scan compare, result regs.
// ----------------------------------------------------------------------------
module iile_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  iile_pkg::ctl_cmd_t                  cmd,
    output iile_pkg::dp_stat_t                  stat,
    input  iile_pkg::req_t                      in_req,
    input  logic [iile_pkg::POS_W-1:0]          in_pos,
    input  logic signed [iile_pkg::DATA_W-1:0]  in_val,
    output logic [iile_pkg::ST_W-1:0]           out_status,
    output logic signed [iile_pkg::DATA_W-1:0]  out_data,
    output logic [iile_pkg::LEN_W-1:0]          out_len
);

    import iile_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    req_t                     req_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            jdx_reg, jdx_next;
    logic [DATA_W-1:0]        tmp_reg;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     found_reg, found_next;
    st_t                      st_reg, st_next;
    logic                     pw_vld_reg, pw_vld_next;
    logic [AW-1:0]            pw_addr_reg, pw_addr_next;
    logic                     sv_reg, sv_next;
    logic [AW-1:0]            sidx_reg;
    logic [ST_W-1:0]          ost_reg;
    logic signed [DATA_W-1:0] odata_reg;
    logic [LEN_W-1:0]         olen_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [DATA_W-1:0]        ram_wdata, ram_rdata;
    logic [WW-1:0]            pos_w, cnt_w, idx_w;
    logic                     miss;

    iile_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_w = WW'(pos_reg);
    assign cnt_w = WW'(cnt_reg);
    assign idx_w = WW'(idx_reg);

    always_comb
    begin
        stat.req        = req_reg;
        stat.full       = (cnt_reg >= CW'(CAPACITY));
        stat.pos_gt_cnt = (pos_w > cnt_w);
        stat.pos_ge_cnt = (pos_w >= cnt_w);
        stat.cnt_gt1    = (cnt_reg > CW'(1));
        stat.idx_eq_pos = (idx_w == pos_w);
        stat.idx_lt_cnt = (idx_reg < cnt_reg);
        stat.idx_lt_jdx = (idx_reg < jdx_reg);
        stat.match      = sv_reg && (ram_rdata == val_reg);
        stat.scan_pend  = sv_reg;
    end

    // A pending shift write takes the port; the sequencer never overlaps it
    always_comb
    begin
        ram_raddr = cmd.rd_jdx ? AW'(jdx_reg) : AW'(idx_reg);
        ram_we    = 1'b0;
        ram_waddr = AW'(idx_reg);
        ram_wdata = cmd.wd_tmp ? tmp_reg : val_reg;
        if (pw_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pw_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_en)
        begin
            ram_we = 1'b1;
            case (cmd.wa_sel)
                WA_POS:  ram_waddr = AW'(pos_reg);
                WA_CNT:  ram_waddr = AW'(cnt_reg);
                WA_IDX:  ram_waddr = AW'(idx_reg);
                WA_JDX:  ram_waddr = AW'(jdx_reg);
                default: ram_waddr = AW'(idx_reg);
            endcase
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IX_ZERO:    idx_next = '0;
            IX_POS:     idx_next = CW'(pos_reg);
            IX_CNT_DEC: idx_next = cnt_reg - CW'(1);
            IX_INC:     idx_next = idx_reg + CW'(1);
            IX_DEC:     idx_next = idx_reg - CW'(1);
            default:    idx_next = idx_reg;
        endcase

        case (cmd.jdx_op)
            JX_CNT_DEC: jdx_next = cnt_reg - CW'(1);
            JX_DEC:     jdx_next = jdx_reg - CW'(1);
            default:    jdx_next = jdx_reg;
        endcase

        case (cmd.cnt_op)
            CN_INC:  cnt_next = cnt_reg + CW'(1);
            CN_DEC:  cnt_next = cnt_reg - CW'(1);
            CN_ZERO: cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase

        pw_vld_next  = (cmd.mv != MV_NONE);
        pw_addr_next = (cmd.mv == MV_UP) ? AW'(idx_reg + CW'(1)) : AW'(idx_reg - CW'(1));
        sv_next      = cmd.scan_rd;

        st_next = st_reg;
        if (cmd.st_set)
        begin
            st_next = cmd.st_code;
        end
        else if (cmd.init)
        begin
            st_next = ST_OK;
        end

        acc_next   = acc_reg;
        found_next = found_reg;
        if (cmd.init)
        begin
            acc_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.capt)
        begin
            acc_next = ram_rdata;
        end
        else if (stat.match)
        begin
            if (req_reg == RQ_COUNT)
            begin
                acc_next = acc_reg + 32'sd1;
            end
            else if (!found_reg)
            begin
                acc_next   = DATA_W'(sidx_reg);
                found_next = 1'b1;
            end
        end
    end

    assign miss = (req_reg == RQ_FIND) && !found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            pw_vld_reg <= 1'b0;
            sv_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            pw_vld_reg <= pw_vld_next;
            sv_reg     <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= in_req;
            pos_reg <= in_pos;
            val_reg <= in_val;
        end
        if (cmd.tmp_load)
        begin
            tmp_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            ost_reg   <= (miss && (st_reg == ST_OK)) ? ST_MISSING : st_reg;
            odata_reg <= miss ? '1 : acc_reg;
            olen_reg  <= LEN_W'(cnt_reg);
        end
        idx_reg     <= idx_next;
        jdx_reg     <= jdx_next;
        acc_reg     <= acc_next;
        found_reg   <= found_next;
        st_reg      <= st_next;
        pw_addr_reg <= pw_addr_next;
        sidx_reg    <= AW'(idx_reg);
    end

    assign out_status = ost_reg;
    assign out_data   = odata_reg;
    assign out_len    = olen_reg;

endmodule
